// File: design/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
// Used by the cell row, the controller and the port checker; no dependencies.
package stq_pkg;

    localparam int TIME_W  = 32;
    localparam int ID_W    = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;
    localparam int REQ_W   = 4;
    localparam int STAT_W  = 3;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 80;

    typedef enum logic [REQ_W-1:0] {
        REQ_SORTED    = 4'd0,
        REQ_APPEND    = 4'd1,
        REQ_PREPEND   = 4'd2,
        REQ_SECOND    = 4'd3,
        REQ_POP_FIRST = 4'd4,
        REQ_POP_LAST  = 4'd5,
        REQ_REMOVE_AT = 4'd6,
        REQ_READ_AT   = 4'd7,
        REQ_FIND_ID   = 4'd8
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_LOAD,
        ACT_FROM_LEFT,
        ACT_FROM_RIGHT
    } cell_act_t;

    typedef struct packed {
        logic      cmp_en;
        cell_act_t act;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE
    } list_op_t;

endpackage

// File: design/stq_cell.sv
// One slot of the queue: holds one entry and its compare flags.
// Depends on stq_pkg; shifts with its left and right neighbors.
module stq_cell
    import stq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic [TIME_W-1:0] cmp_time,
    input  logic [ID_W-1:0]   cmp_id,
    input  logic [TIME_W-1:0] new_time,
    input  logic [ID_W-1:0]   new_id,
    input  logic [TIME_W-1:0] left_time,
    input  logic [ID_W-1:0]   left_id,
    input  logic [TIME_W-1:0] right_time,
    input  logic [ID_W-1:0]   right_id,
    output logic [TIME_W-1:0] cur_time,
    output logic [ID_W-1:0]   cur_id,
    output logic              ge,
    output logic              le,
    output logic              match
);

    logic [TIME_W-1:0] time_reg;
    logic [ID_W-1:0]   id_reg;
    logic              ge_reg;
    logic              le_reg;
    logic              match_reg;

    always_ff @(posedge clk)
    begin
        unique case (ctl.act)
            ACT_LOAD:
            begin
                time_reg <= new_time;
                id_reg   <= new_id;
            end
            ACT_FROM_LEFT:
            begin
                time_reg <= left_time;
                id_reg   <= left_id;
            end
            ACT_FROM_RIGHT:
            begin
                time_reg <= right_time;
                id_reg   <= right_id;
            end
            default:
            begin
                time_reg <= time_reg;
                id_reg   <= id_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg    <= 1'b0;
            le_reg    <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            ge_reg    <= (time_reg >= cmp_time);
            le_reg    <= (time_reg <= cmp_time);
            match_reg <= (id_reg == cmp_id);
        end
    end

    assign cur_time = time_reg;
    assign cur_id   = id_reg;
    assign ge       = ge_reg;
    assign le       = le_reg;
    assign match    = match_reg;

endmodule

// File: design/stq_ctrl.sv
// Request sequencer: latches a request, picks the slot, steers the cell row
// and registers the result. Depends on stq_pkg.
module stq_ctrl
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [REQ_W-1:0]    s_tuser,
    input  logic [TIME_W-1:0]   req_time,
    input  logic [ID_W-1:0]     req_id,
    input  logic [POS_W-1:0]    req_pos,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STAT_W-1:0]   m_tuser,
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic [TIME_W-1:0]   cell_time [QUEUE_DEPTH],
    input  logic [ID_W-1:0]     cell_id [QUEUE_DEPTH],
    input  logic [QUEUE_DEPTH-1:0] cell_ge,
    input  logic [QUEUE_DEPTH-1:0] cell_le,
    input  logic [QUEUE_DEPTH-1:0] cell_match,
    output cell_ctl_t           cell_ctl [QUEUE_DEPTH],
    output logic [TIME_W-1:0]   new_time,
    output logic [ID_W-1:0]     new_id
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [REQ_W-1:0]    req_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [ID_W-1:0]     id_reg;
    logic [POS_W-1:0]    pos_reg;

    logic                m_valid_reg;
    logic [STAT_W-1:0]   m_status_reg;
    logic [TIME_W-1:0]   m_time_reg;
    logic [ID_W-1:0]     m_id_reg;
    logic [POS_W-1:0]    m_pos_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic                accept;
    logic                exec_fire;
    logic                empty;
    logic                full;
    logic [CNT_W-1:0]    tail;
    logic [CNT_W-1:0]    first_ge;
    logic [CNT_W-1:0]    sorted_at;
    logic                found;
    logic [IDX_W-1:0]    found_idx;
    logic [CNT_W+3:0]    pos_ext;
    logic [CNT_W+3:0]    fill_ext;
    logic [IDX_W+3:0]    opos_ext;
    logic [CNT_W+4:0]    count_ext;
    list_op_t            op;
    logic [CNT_W-1:0]    at;
    status_t             status;
    logic [TIME_W-1:0]   ot;
    logic [ID_W-1:0]     oid;
    logic [POS_W-1:0]    opos;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign tail     = fill_reg - CNT_W'(1);
    assign pos_ext  = {{CNT_W{1'b0}}, pos_reg};
    assign fill_ext = {4'b0, fill_reg};

    always_comb
    begin
        first_ge  = fill_reg;
        found     = 1'b0;
        found_idx = '0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--)
        begin
            if (k > 0 && cell_ge[k] && (CNT_W'(k) < fill_reg))
                first_ge = CNT_W'(k);
            if (cell_match[k] && (CNT_W'(k) < fill_reg))
            begin
                found     = 1'b1;
                found_idx = IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        if (empty || cell_ge[0])
            sorted_at = '0;
        else if (cell_le[tail[IDX_W-1:0]])
            sorted_at = fill_reg;
        else
            sorted_at = first_ge;
    end

    assign opos_ext = {4'b0, found_idx};

    always_comb
    begin
        status    = ST_OK;
        op        = OP_NONE;
        at        = '0;
        fill_next = fill_reg;
        ot        = '0;
        oid       = '0;
        opos      = '0;
        case (req_t'(req_reg))
            REQ_SORTED, REQ_APPEND, REQ_PREPEND, REQ_SECOND:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    op        = OP_INSERT;
                    fill_next = fill_reg + CNT_W'(1);
                    case (req_t'(req_reg))
                        REQ_SORTED: at = sorted_at;
                        REQ_APPEND: at = fill_reg;
                        REQ_SECOND: at = empty ? '0 : CNT_W'(1);
                        default:    at = '0;
                    endcase
                end
            end
            REQ_POP_FIRST, REQ_POP_LAST:
            begin
                if (empty)
                    status = ST_EMPTY;
                else
                begin
                    op        = OP_REMOVE;
                    at        = (req_t'(req_reg) == REQ_POP_FIRST) ? '0 : tail;
                    fill_next = tail;
                    ot        = cell_time[at[IDX_W-1:0]];
                    oid       = cell_id[at[IDX_W-1:0]];
                end
            end
            REQ_REMOVE_AT, REQ_READ_AT:
            begin
                if (empty)
                    status = ST_EMPTY;
                else if (pos_ext >= fill_ext)
                    status = ST_RANGE;
                else
                begin
                    at  = pos_ext[CNT_W-1:0];
                    ot  = cell_time[pos_ext[IDX_W-1:0]];
                    oid = cell_id[pos_ext[IDX_W-1:0]];
                    if (req_t'(req_reg) == REQ_REMOVE_AT)
                    begin
                        op        = OP_REMOVE;
                        fill_next = tail;
                    end
                end
            end
            REQ_FIND_ID:
            begin
                if (found)
                    opos = opos_ext[POS_W-1:0];
                else
                    status = ST_NOTFOUND;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign count_ext = {5'b0, fill_next};

    always_comb
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            cell_ctl[k].cmp_en = accept;
            cell_ctl[k].act    = ACT_HOLD;
            if (exec_fire && op == OP_INSERT)
            begin
                if (CNT_W'(k) == at)
                    cell_ctl[k].act = ACT_LOAD;
                else if (CNT_W'(k) > at)
                    cell_ctl[k].act = ACT_FROM_LEFT;
            end
            else if (exec_fire && op == OP_REMOVE && CNT_W'(k) >= at)
                cell_ctl[k].act = ACT_FROM_RIGHT;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_EXEC;
            S_EXEC: if (exec_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                fill_reg    <= fill_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= s_tuser;
            time_reg <= req_time;
            id_reg   <= req_id;
            pos_reg  <= req_pos;
        end
        if (exec_fire)
        begin
            m_status_reg <= status;
            m_time_reg   <= ot;
            m_id_reg     <= oid;
            m_pos_reg    <= opos;
            m_count_reg  <= count_ext[COUNT_W-1:0];
        end
    end

    assign new_time = time_reg;
    assign new_id   = id_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'b0, m_count_reg, m_pos_reg, m_id_reg, m_time_reg};

endmodule

// File: design/sorted_timer_queue_top.sv
// Top level of the sorted timer queue: a row of entry cells and the sequencer.
// Depends on stq_pkg, stq_cell and stq_ctrl.
//
//  channel | dir | tuser          | tdata (low bit up)
//  s       | in  | req_type[3:0]  | wake_time[31:0], entry_id[31:0], position[3:0]
//  m       | out | status[2:0]    | out_time[31:0], out_id[31:0], out_position[3:0],
//          |     |                | entry_count[4:0]
//
// For each request the cells compare against it as it is taken; the S_EXEC
// state then picks the slot and shifts the row in one step.
// The result register frees the cell row; a stalled result holds the S_EXEC state.
// Reset empties the queue at once; entry contents stay undefined until written.
module sorted_timer_queue_top
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [REQ_W-1:0]    s_tuser,   // req_type
    input  logic [S_DATA_W-1:0] s_tdata,   // wake_time, entry_id, position, pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STAT_W-1:0]   m_tuser,   // status
    output logic [M_DATA_W-1:0] m_tdata    // out_time, out_id, out_position, entry_count, pad
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [TIME_W-1:0]      req_time;
    logic [ID_W-1:0]        req_id;
    logic [POS_W-1:0]       req_pos;
    logic [TIME_W-1:0]      cell_time [QUEUE_DEPTH];
    logic [ID_W-1:0]        cell_id [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_ge;
    logic [QUEUE_DEPTH-1:0] cell_le;
    logic [QUEUE_DEPTH-1:0] cell_match;
    cell_ctl_t              cell_ctl [QUEUE_DEPTH];
    logic [TIME_W-1:0]      new_time;
    logic [ID_W-1:0]        new_id;

    assign req_time = s_tdata[TIME_W-1:0];
    assign req_id   = s_tdata[TIME_W+ID_W-1:TIME_W];
    assign req_pos  = s_tdata[TIME_W+ID_W+POS_W-1:TIME_W+ID_W];

    stq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .req_time   (req_time),
        .req_id     (req_id),
        .req_pos    (req_pos),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .cell_time  (cell_time),
        .cell_id    (cell_id),
        .cell_ge    (cell_ge),
        .cell_le    (cell_le),
        .cell_match (cell_match),
        .cell_ctl   (cell_ctl),
        .new_time   (new_time),
        .new_id     (new_id)
    );

    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_cell
        localparam int L = (k == 0) ? 0 : k - 1;
        localparam int R = (k == QUEUE_DEPTH - 1) ? k : k + 1;

        stq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl[k]),
            .cmp_time   (req_time),
            .cmp_id     (req_id),
            .new_time   (new_time),
            .new_id     (new_id),
            .left_time  (cell_time[L]),
            .left_id    (cell_id[L]),
            .right_time (cell_time[R]),
            .right_id   (cell_id[R]),
            .cur_time   (cell_time[k]),
            .cur_id     (cell_id[k]),
            .ge         (cell_ge[k]),
            .le         (cell_le[k]),
            .match      (cell_match[k])
        );
    end

endmodule

// File: design/stq_checker.sv
// Port-level checks for the sorted timer queue, bound to the top level.
// Depends on stq_pkg and sorted_timer_queue_top.
module stq_checker
    import stq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [STAT_W-1:0]   m_tuser,
    input logic [M_DATA_W-1:0] m_tdata
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one in flight");

    a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a pending request");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL
                      || m_tuser == ST_RANGE || m_tuser == ST_NOTFOUND))
        else $error("undefined status");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[72:68] == 5'd0
                                               && m_tdata[63:0] == 64'd0))
        else $error("empty status with entries or data");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (.*);
